// ----- src/assert_macros.svh -----
// Assertion macros shared by the window patch extractor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpe: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpe: next-cycle check failed");

`endif

// ----- src/wpe_pkg.sv -----
// Package with constants and types of the window patch extractor.
`default_nettype none
package wpe_pkg;

    localparam int DEF_IMAGE_SIDE     = 28;
    localparam int DEF_PADDED_PATCHES = 172;
    localparam int DEF_GROUP_LANES    = 4;

    localparam int PIX_W       = 8;
    localparam int WORD_W      = 32;
    localparam int GROUP_IDX_W = 6;
    localparam int TAP_W       = 4;
    localparam int TAPS        = 9;
    localparam int PACK_MAX    = 4;
    localparam int LANE_W      = 3;
    localparam int GROUP_W     = 14;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);

    typedef struct packed {
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   mid;
        logic [PIX_W-1:0]   bot;
        logic               wr_last;
        logic [LANE_W-1:0]  lane_last;
        logic               wr_first;
        logic               col_first;
        logic [LANE_W-1:0]  lane_first;
        logic               emit;
        logic [GROUP_W-1:0] group;
        logic               clear;
    } t_col_op;

endpackage
`default_nettype wire

// ----- src/wpe_pixel_if.sv -----
// Handshake channel that carries one pixel item.
`default_nettype none
interface wpe_pixel_if import wpe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

// ----- src/wpe_word_if.sv -----
// Handshake channel that carries one packed output word item.
`default_nettype none
interface wpe_word_if import wpe_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [GROUP_IDX_W-1:0] group_index;
    logic [TAP_W-1:0]       tap_index;
    logic [WORD_W-1:0]      packed_word;
    logic                   last_of_group;
    logic                   last_of_image;

    modport source (output valid, output group_index, output tap_index, output packed_word,
                    output last_of_group, output last_of_image, input ready);
    modport sink (input valid, input group_index, input tap_index, input packed_word,
                  input last_of_group, input last_of_image, output ready);
endinterface
`default_nettype wire

// ----- src/wpe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wpe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 28
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- src/wpe_fifo.sv -----
// Short register queue between the pixel front end and the gather back end.
`default_nettype none
`include "assert_macros.svh"
module wpe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    `WPE_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, r_count != CW'(DEPTH))
    `WPE_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
endmodule
`default_nettype wire

// ----- src/wpe_front.sv -----
// Front end: line store, position counters and per-pixel column classification.
`default_nettype none
module wpe_front import wpe_pkg::*; #(
    parameter int IMAGE_SIDE  = DEF_IMAGE_SIDE,
    parameter int GROUP_LANES = DEF_GROUP_LANES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wpe_pixel_if.sink  i_pixel_if,
    input  wire logic  i_queue_full,
    output logic       o_push,
    output t_col_op    o_op
);
    localparam int CW = $clog2(IMAGE_SIDE);

    logic             r_s1_valid;
    logic [CW-1:0]    r_col, r_row, r_s1_col, r_s1_row;
    logic [PIX_W-1:0] r_s1_px;
    logic [LANE_W-1:0]  r_lane;
    logic [GROUP_W-1:0] r_group;
    logic [2*PIX_W-1:0] rd_rows;

    logic in_fire, s1_fire;
    logic row_act, fit, wr_last, complete, end_img, partial;
    logic [LANE_W-1:0] lane_inc, lane_after;

    assign s1_fire          = r_s1_valid && !i_queue_full;
    assign i_pixel_if.ready = i_rst_n && (!r_s1_valid || s1_fire);
    assign in_fire          = i_pixel_if.valid && i_pixel_if.ready;

    wpe_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (IMAGE_SIDE)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata ({rd_rows[PIX_W-1:0], r_s1_px}),
        .i_re    (in_fire),
        .i_raddr (r_col),
        .o_rdata (rd_rows)
    );

    always_comb begin
        row_act    = (r_s1_row >= CW'(2)) && !r_s1_row[0];
        fit        = ({1'b0, r_s1_col} + (CW+1)'(2)) <= (CW+1)'(IMAGE_SIDE - 1);
        wr_last    = row_act && !r_s1_col[0] && (r_s1_col >= CW'(2));
        lane_inc   = (r_lane == LANE_W'(GROUP_LANES - 1)) ? '0 : r_lane + 1'b1;
        complete   = wr_last && (r_lane == LANE_W'(GROUP_LANES - 1));
        lane_after = wr_last ? lane_inc : r_lane;
        end_img    = (r_s1_col == CW'(IMAGE_SIDE - 1)) && (r_s1_row == CW'(IMAGE_SIDE - 1));
        partial    = end_img && !complete && (lane_after != '0);

        o_op.top        = rd_rows[2*PIX_W-1:PIX_W];
        o_op.mid        = rd_rows[PIX_W-1:0];
        o_op.bot        = r_s1_px;
        o_op.wr_last    = wr_last;
        o_op.lane_last  = r_lane;
        o_op.wr_first   = row_act && fit;
        o_op.col_first  = r_s1_col[0];
        o_op.lane_first = lane_after;
        o_op.emit       = complete || partial;
        o_op.group      = r_group;
        o_op.clear      = end_img;
    end

    assign o_push = s1_fire;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_px  <= i_pixel_if.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_lane     <= '0;
            r_group    <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                if (r_col == CW'(IMAGE_SIDE - 1)) begin
                    r_col <= '0;
                    r_row <= (r_row == CW'(IMAGE_SIDE - 1)) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_lane  <= end_img ? '0 : lane_after;
                r_group <= end_img ? '0 : (complete ? r_group + 1'b1 : r_group);
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/wpe_back.sv -----
// Back end: patch gather registers, group snapshot and word output.
`default_nettype none
`include "assert_macros.svh"
module wpe_back import wpe_pkg::*; #(
    parameter int PADDED_PATCHES = DEF_PADDED_PATCHES,
    parameter int GROUP_LANES    = DEF_GROUP_LANES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  t_col_op     i_op,
    output logic        o_pop,
    wpe_word_if.source  o_word_if
);
    localparam int PACK       = (GROUP_LANES < PACK_MAX) ? GROUP_LANES : PACK_MAX;
    localparam int LAST_GROUP = PADDED_PATCHES / GROUP_LANES - 1;

    logic [PACK-1:0][TAPS-1:0][PIX_W-1:0] r_gather, g_a, g_b;
    logic [TAPS-1:0][WORD_W-1:0]          r_snap, n_snap;
    logic                                 r_busy;
    logic [TAP_W-1:0]                     r_tap;
    logic [GROUP_W-1:0]                   r_grp;
    logic                                 out_fire, snap_free;

    assign out_fire  = o_word_if.valid && o_word_if.ready;
    assign snap_free = !r_busy || (out_fire && (r_tap == TAP_LAST));
    assign o_pop     = !i_empty && (!i_op.emit || snap_free);

    always_comb begin
        g_a = r_gather;
        for (int k = 0; k < PACK; k++) begin
            if (i_op.wr_last && (i_op.lane_last == LANE_W'(k))) begin
                g_a[k][2] = i_op.top;
                g_a[k][5] = i_op.mid;
                g_a[k][8] = i_op.bot;
            end
        end
        for (int t = 0; t < TAPS; t++) begin
            n_snap[t] = '0;
            for (int k = 0; k < PACK; k++) begin
                n_snap[t][8*k +: 8] = g_a[k][t];
            end
        end
        g_b = i_op.emit ? '0 : g_a;
        for (int k = 0; k < PACK; k++) begin
            if (i_op.wr_first && (i_op.lane_first == LANE_W'(k))) begin
                if (i_op.col_first) begin
                    g_b[k][1] = i_op.top;
                    g_b[k][4] = i_op.mid;
                    g_b[k][7] = i_op.bot;
                end else begin
                    g_b[k][0] = i_op.top;
                    g_b[k][3] = i_op.mid;
                    g_b[k][6] = i_op.bot;
                end
            end
        end
        if (i_op.clear) begin
            g_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.emit) begin
            r_snap <= n_snap;
            r_grp  <= i_op.group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= '0;
            r_busy   <= 1'b0;
            r_tap    <= '0;
        end else begin
            if (o_pop) begin
                r_gather <= g_b;
            end
            if (o_pop && i_op.emit) begin
                r_busy <= 1'b1;
                r_tap  <= '0;
            end else if (out_fire) begin
                if (r_tap == TAP_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_tap <= r_tap + 1'b1;
                end
            end
        end
    end

    assign o_word_if.valid         = r_busy;
    assign o_word_if.group_index   = r_grp[GROUP_IDX_W-1:0];
    assign o_word_if.tap_index     = r_tap;
    assign o_word_if.packed_word   = r_snap[r_tap];
    assign o_word_if.last_of_group = (r_tap == TAP_LAST);
    assign o_word_if.last_of_image = (r_tap == TAP_LAST) && (r_grp == GROUP_W'(LAST_GROUP));

    `WPE_ASSERT_NOW(a_snap_free_on_load, i_clk, i_rst_n, o_pop && i_op.emit, snap_free)
    `WPE_ASSERT_NEXT(a_tap_in_range, i_clk, i_rst_n, r_busy, r_tap <= TAP_LAST)
endmodule
`default_nettype wire

// ----- src/window_patch_extract_pack.sv -----
// Top level of the 3x3 stride-2 window patch extractor with four-lane packing.
`default_nettype none
// Pixels of a square image enter one per cycle in raster order while the input is
// ready; the front end reads the two stored rows from the line RAM and classifies
// each pixel into column writes for the patch gather. A four-entry queue separates
// the front end from the back end, which applies those writes and, when a group of
// patches completes, snapshots the group and sends its nine tap words one per cycle
// while the output is ready. The word output port is the limit: a group spans eight
// or more pixels but sends nine words, so on window rows the input is throttled once
// the queue fills.
module window_patch_extract_pack import wpe_pkg::*; #(
    parameter int IMAGE_SIDE     = DEF_IMAGE_SIDE,
    parameter int PADDED_PATCHES = DEF_PADDED_PATCHES,
    parameter int GROUP_LANES    = DEF_GROUP_LANES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wpe_pixel_if.sink  i_pixel_if,
    wpe_word_if.source o_word_if
);
    localparam int OP_W = $bits(t_col_op);

    logic              push, pop, full, empty;
    t_col_op           front_op, back_op;
    logic [OP_W-1:0]   queue_out;

    wpe_front #(
        .IMAGE_SIDE  (IMAGE_SIDE),
        .GROUP_LANES (GROUP_LANES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pixel_if   (i_pixel_if),
        .i_queue_full (full),
        .o_push       (push),
        .o_op         (front_op)
    );

    wpe_fifo #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_out),
        .o_empty (empty)
    );

    assign back_op = t_col_op'(queue_out);

    wpe_back #(
        .PADDED_PATCHES (PADDED_PATCHES),
        .GROUP_LANES    (GROUP_LANES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_op      (back_op),
        .o_pop     (pop),
        .o_word_if (o_word_if)
    );
endmodule
`default_nettype wire
